@@ rtl/qpc_pkg.sv @@
// qpc_pkg: shared types, latencies, rounding and saturation helpers for the pose composition pipeline
// no dependencies
package qpc_pkg;

	localparam int LANE_W    = 16;
	localparam int UNIT_W    = 26;
	localparam int FRAC_W    = 24;
	localparam int POS_W     = 32;
	localparam int SQ_STEPS  = 32;
	localparam int DIV_STEPS = 26;
	localparam int UNIT_LAT  = 3 + (SQ_STEPS + 1) + (DIV_STEPS + 1) + 1;
	localparam int XF_LAT    = 7;
	localparam int TOTAL_LAT = UNIT_LAT + XF_LAT;

	typedef logic signed [UNIT_W-1:0] unit_t;
	typedef logic signed [POS_W-1:0]  pos_t;

	typedef struct packed {
		logic [4:0]              k;
		logic                    zero;
		logic [3:0]              neg;
		logic [3:0][LANE_W-1:0]  mag;
	} side_t;

	typedef struct packed {
		pos_t bx;
		pos_t by;
		pos_t bz;
		pos_t vx;
		pos_t vy;
		pos_t vz;
	} posset_t;

	// divide by 2^s, half away from zero
	function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] x,
		input int s);
		logic [63:0] m;
		logic [63:0] h;
		h = 64'd1 << (s - 1);
		m = x[63] ? (64'd0 - 64'(x)) : 64'(x);
		m = (m + h) >> s;
		return x[63] ? -$signed(m) : $signed(m);
	endfunction

	function automatic logic [LANE_W-1:0] sat16(input logic signed [63:0] x);
		if (x > 64'sd32767) begin
			return 16'h7fff;
		end else if (x < -64'sd32768) begin
			return 16'h8000;
		end
		return x[15:0];
	endfunction

	function automatic logic [POS_W-1:0] sat32(input logic signed [63:0] x);
		if (x > 64'sd2147483647) begin
			return 32'h7fffffff;
		end else if (x < -64'sd2147483648) begin
			return 32'h80000000;
		end
		return x[31:0];
	endfunction

endpackage

@@ rtl/qpc_unit.sv @@
// qpc_unit: quaternion normaliser, sum of squares, root and per-lane division stages
// depends on qpc_pkg
module qpc_unit (
	input  logic               clk,
	input  logic               en,
	input  logic [63:0]        rot,
	output qpc_pkg::unit_t     q [4]
);

	localparam int SQN = qpc_pkg::SQ_STEPS;
	localparam int DVN = qpc_pkg::DIV_STEPS;

	logic [30:0]             sq_s1 [4];
	logic [3:0][15:0]        mag_s1;
	logic [3:0]              neg_s1;
	logic [32:0]             s_s2;
	logic [3:0][15:0]        mag_s2;
	logic [3:0]              neg_s2;
	logic [32:0]             s_s3;
	qpc_pkg::side_t          sd_s3;

	logic [35:0]             rem_s  [SQN+1];
	logic [31:0]             root_s [SQN+1];
	logic [63:0]             t_s    [SQN+1];
	qpc_pkg::side_t          sq_sd_s [SQN+1];

	logic [32:0]             d_s    [DVN+1];
	logic [32:0]             dr_s   [DVN+1][4];
	logic [DVN-1:0]          nlo_s  [DVN+1][4];
	logic [DVN-1:0]          quo_s  [DVN+1][4];
	qpc_pkg::side_t          dv_sd_s [DVN+1];

	logic [3:0][15:0]        mag_c;
	logic [3:0]              neg_c;
	logic [4:0]              k_c;
	logic [35:0]             rem_n  [SQN+1];
	logic [31:0]             root_n [SQN+1];
	logic [32:0]             dr_n   [DVN+1][4];
	logic [DVN-1:0]          quo_n  [DVN+1][4];
	logic [71:0]             num_c  [4];

	always_comb begin
		logic signed [15:0] lv;
		logic [63:0]        sh;
		for (int i = 0; i < 4; i++) begin
			lv = rot[16*i +: 16];
			neg_c[i] = lv[15];
			mag_c[i] = lv[15] ? (16'd0 - 16'(lv)) : 16'(lv);
		end
		k_c = 5'd30;
		for (int kk = 30; kk >= 0; kk--) begin
			sh = {31'd0, s_s2} << (2 * kk);
			if (sh[63:60] != 4'd0) begin
				k_c = 5'(kk);
			end
		end
	end

	always_comb begin
		logic [35:0] r2;
		logic [35:0] tr;
		rem_n[0]  = '0;
		root_n[0] = '0;
		for (int j = 1; j <= SQN; j++) begin
			r2 = {rem_s[j-1][33:0], t_s[j-1][63:62]};
			tr = {2'd0, root_s[j-1], 2'b01};
			if (r2 >= tr) begin
				rem_n[j]  = r2 - tr;
				root_n[j] = {root_s[j-1][30:0], 1'b1};
			end else begin
				rem_n[j]  = r2;
				root_n[j] = {root_s[j-1][30:0], 1'b0};
			end
		end
	end

	always_comb begin
		logic [33:0] r2;
		for (int i = 0; i < 4; i++) begin
			num_c[i] = (72'(sq_sd_s[SQN].mag[i]) << (25 + int'(sq_sd_s[SQN].k)))
				+ 72'(root_s[SQN]);
			dr_n[0][i]  = '0;
			quo_n[0][i] = '0;
		end
		for (int j = 1; j <= DVN; j++) begin
			for (int i = 0; i < 4; i++) begin
				r2 = {dr_s[j-1][i], nlo_s[j-1][i][DVN-1]};
				if (r2 >= {1'b0, d_s[j-1]}) begin
					dr_n[j][i]  = 33'(r2 - {1'b0, d_s[j-1]});
					quo_n[j][i] = {quo_s[j-1][i][DVN-2:0], 1'b1};
				end else begin
					dr_n[j][i]  = r2[32:0];
					quo_n[j][i] = {quo_s[j-1][i][DVN-2:0], 1'b0};
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				sq_s1[i] <= 31'(32'(mag_c[i]) * 32'(mag_c[i]));
			end
			mag_s1 <= mag_c;
			neg_s1 <= neg_c;

			s_s2   <= 33'(sq_s1[0]) + 33'(sq_s1[1]) + 33'(sq_s1[2]) + 33'(sq_s1[3]);
			mag_s2 <= mag_s1;
			neg_s2 <= neg_s1;

			s_s3      <= s_s2;
			sd_s3.k    <= k_c;
			sd_s3.zero <= (s_s2 == 33'd0);
			sd_s3.neg  <= neg_s2;
			sd_s3.mag  <= mag_s2;

			rem_s[0]   <= '0;
			root_s[0]  <= '0;
			t_s[0]     <= {31'd0, s_s3} << {sd_s3.k, 1'b0};
			sq_sd_s[0] <= sd_s3;
			for (int j = 1; j <= SQN; j++) begin
				rem_s[j]   <= rem_n[j];
				root_s[j]  <= root_n[j];
				t_s[j]     <= {t_s[j-1][61:0], 2'b00};
				sq_sd_s[j] <= sq_sd_s[j-1];
			end

			d_s[0]     <= {root_s[SQN], 1'b0};
			dv_sd_s[0] <= sq_sd_s[SQN];
			for (int i = 0; i < 4; i++) begin
				dr_s[0][i]  <= num_c[i][DVN +: 33];
				nlo_s[0][i] <= num_c[i][DVN-1:0];
				quo_s[0][i] <= '0;
			end
			for (int j = 1; j <= DVN; j++) begin
				d_s[j]     <= d_s[j-1];
				dv_sd_s[j] <= dv_sd_s[j-1];
				for (int i = 0; i < 4; i++) begin
					dr_s[j][i]  <= dr_n[j][i];
					nlo_s[j][i] <= {nlo_s[j-1][i][DVN-2:0], 1'b0};
					quo_s[j][i] <= quo_n[j][i];
				end
			end

			for (int i = 0; i < 4; i++) begin
				if (dv_sd_s[DVN].zero) begin
					q[i] <= (i == 3) ? qpc_pkg::unit_t'(1 << qpc_pkg::FRAC_W) : '0;
				end else if (dv_sd_s[DVN].neg[i]) begin
					q[i] <= -$signed(quo_s[DVN][i]);
				end else begin
					q[i] <= $signed(quo_s[DVN][i]);
				end
			end
		end
	end

endmodule

@@ rtl/qpc_xform.sv @@
// qpc_xform: rotation of the offset, position add with saturation, quaternion product
// depends on qpc_pkg
module qpc_xform (
	input  logic               clk,
	input  logic               en,
	input  qpc_pkg::unit_t     p [4],
	input  qpc_pkg::unit_t     o [4],
	input  qpc_pkg::posset_t   pos,
	output logic [31:0]        px,
	output logic [31:0]        py,
	output logic [31:0]        pz,
	output logic [63:0]        rot
);

	logic signed [57:0]  pv_s1 [6];
	logic signed [51:0]  qq_s1 [4][4];
	qpc_pkg::unit_t      p_s1 [4];
	qpc_pkg::posset_t    pos_s1;

	logic signed [58:0]  c_s2 [3];
	logic signed [53:0]  qa_s2 [4];
	qpc_pkg::unit_t      p_s2 [4];
	qpc_pkg::posset_t    pos_s2;

	logic signed [35:0]  cr_s3 [3];
	logic [63:0]         rot_s3;
	qpc_pkg::unit_t      p_s3 [4];
	qpc_pkg::posset_t    pos_s3;

	logic signed [61:0]  m_s4 [9];
	logic [63:0]         rot_s4;
	qpc_pkg::posset_t    pos_s4;

	logic signed [63:0]  acc_s5 [3];
	logic [63:0]         rot_s5;
	qpc_pkg::posset_t    pos_s5;

	logic signed [39:0]  r_s6 [3];
	logic [63:0]         rot_s6;
	qpc_pkg::posset_t    pos_s6;

	logic signed [63:0]  sum_c [3];

	always_comb begin
		sum_c[0] = 64'(pos_s6.bx) + 64'(r_s6[0]);
		sum_c[1] = 64'(pos_s6.by) + 64'(r_s6[1]);
		sum_c[2] = 64'(pos_s6.bz) + 64'(r_s6[2]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pv_s1[0] <= 58'(p[1]) * 58'(pos.vz);
			pv_s1[1] <= 58'(p[2]) * 58'(pos.vy);
			pv_s1[2] <= 58'(p[2]) * 58'(pos.vx);
			pv_s1[3] <= 58'(p[0]) * 58'(pos.vz);
			pv_s1[4] <= 58'(p[0]) * 58'(pos.vy);
			pv_s1[5] <= 58'(p[1]) * 58'(pos.vx);
			for (int i = 0; i < 4; i++) begin
				for (int j = 0; j < 4; j++) begin
					qq_s1[i][j] <= 52'(p[i]) * 52'(o[j]);
				end
			end
			p_s1   <= p;
			pos_s1 <= pos;

			c_s2[0] <= 59'(pv_s1[0]) - 59'(pv_s1[1]);
			c_s2[1] <= 59'(pv_s1[2]) - 59'(pv_s1[3]);
			c_s2[2] <= 59'(pv_s1[4]) - 59'(pv_s1[5]);
			qa_s2[0] <= 54'(qq_s1[3][0]) + 54'(qq_s1[0][3]) + 54'(qq_s1[1][2])
				- 54'(qq_s1[2][1]);
			qa_s2[1] <= 54'(qq_s1[3][1]) - 54'(qq_s1[0][2]) + 54'(qq_s1[1][3])
				+ 54'(qq_s1[2][0]);
			qa_s2[2] <= 54'(qq_s1[3][2]) + 54'(qq_s1[0][1]) - 54'(qq_s1[1][0])
				+ 54'(qq_s1[2][3]);
			qa_s2[3] <= 54'(qq_s1[3][3]) - 54'(qq_s1[0][0]) - 54'(qq_s1[1][1])
				- 54'(qq_s1[2][2]);
			p_s2   <= p_s1;
			pos_s2 <= pos_s1;

			for (int i = 0; i < 3; i++) begin
				cr_s3[i] <= 36'(qpc_pkg::rnd_shift(64'(c_s2[i]), qpc_pkg::FRAC_W));
			end
			for (int i = 0; i < 4; i++) begin
				rot_s3[16*i +: 16] <= qpc_pkg::sat16(qpc_pkg::rnd_shift(64'(qa_s2[i]),
					2 * qpc_pkg::FRAC_W - 12));
			end
			p_s3   <= p_s2;
			pos_s3 <= pos_s2;

			m_s4[0] <= 62'(p_s3[3]) * 62'(cr_s3[0]);
			m_s4[1] <= 62'(p_s3[1]) * 62'(cr_s3[2]);
			m_s4[2] <= 62'(p_s3[2]) * 62'(cr_s3[1]);
			m_s4[3] <= 62'(p_s3[3]) * 62'(cr_s3[1]);
			m_s4[4] <= 62'(p_s3[2]) * 62'(cr_s3[0]);
			m_s4[5] <= 62'(p_s3[0]) * 62'(cr_s3[2]);
			m_s4[6] <= 62'(p_s3[3]) * 62'(cr_s3[2]);
			m_s4[7] <= 62'(p_s3[0]) * 62'(cr_s3[1]);
			m_s4[8] <= 62'(p_s3[1]) * 62'(cr_s3[0]);
			rot_s4 <= rot_s3;
			pos_s4 <= pos_s3;

			acc_s5[0] <= (64'(pos_s4.vx) <<< qpc_pkg::FRAC_W)
				+ ((64'(m_s4[0]) + 64'(m_s4[1]) - 64'(m_s4[2])) <<< 1);
			acc_s5[1] <= (64'(pos_s4.vy) <<< qpc_pkg::FRAC_W)
				+ ((64'(m_s4[3]) + 64'(m_s4[4]) - 64'(m_s4[5])) <<< 1);
			acc_s5[2] <= (64'(pos_s4.vz) <<< qpc_pkg::FRAC_W)
				+ ((64'(m_s4[6]) + 64'(m_s4[7]) - 64'(m_s4[8])) <<< 1);
			rot_s5 <= rot_s4;
			pos_s5 <= pos_s4;

			for (int i = 0; i < 3; i++) begin
				r_s6[i] <= 40'(qpc_pkg::rnd_shift(acc_s5[i], qpc_pkg::FRAC_W));
			end
			rot_s6 <= rot_s5;
			pos_s6 <= pos_s5;

			px  <= qpc_pkg::sat32(sum_c[0]);
			py  <= qpc_pkg::sat32(sum_c[1]);
			pz  <= qpc_pkg::sat32(sum_c[2]);
			rot <= rot_s6;
		end
	end

endmodule

@@ rtl/quaternion_pose_compose.sv @@
// quaternion_pose_compose: top level, request handshake, valid chain and position delay line
// depends on qpc_pkg, qpc_unit, qpc_xform
//
// Places a child offset in the frame of a parent pose. Both quaternions are normalised
// (all-zero becomes identity), the offset position is rotated by the parent rotation and
// added to the parent position with Q16.16 saturation, and the rotations are multiplied.
// A fully pipelined datapath takes one request per cycle while out_stall does not hold it;
// the pipeline depth is set by the 32-step square root and 26-step division in the normaliser.
// out_stall freezes the whole pipeline, and in_stall follows it while a result waits.
module quaternion_pose_compose (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_stall,
	input  logic [31:0]  parent_px,
	input  logic [31:0]  parent_py,
	input  logic [31:0]  parent_pz,
	input  logic [63:0]  parent_rot,
	input  logic [31:0]  offset_px,
	input  logic [31:0]  offset_py,
	input  logic [31:0]  offset_pz,
	input  logic [63:0]  offset_rot,
	output logic         out_valid,
	input  logic         out_stall,
	output logic [31:0]  placed_px,
	output logic [31:0]  placed_py,
	output logic [31:0]  placed_pz,
	output logic [63:0]  placed_rot
);

	localparam int UL = qpc_pkg::UNIT_LAT;
	localparam int TL = qpc_pkg::TOTAL_LAT;

	logic                 en;
	logic [TL-1:0]        vld_s;
	qpc_pkg::posset_t     pos_s [UL];
	qpc_pkg::unit_t       pq [4];
	qpc_pkg::unit_t       oq [4];

	assign en        = !(vld_s[TL-1] && out_stall);
	assign in_stall  = !en;
	assign out_valid = vld_s[TL-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[TL-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pos_s[0] <= '{bx: parent_px, by: parent_py, bz: parent_pz,
				vx: offset_px, vy: offset_py, vz: offset_pz};
			for (int j = 1; j < UL; j++) begin
				pos_s[j] <= pos_s[j-1];
			end
		end
	end

	qpc_unit u_par (
		.clk    (clk),
		.en     (en),
		.rot    (parent_rot),
		.q      (pq)
	);

	qpc_unit u_off (
		.clk    (clk),
		.en     (en),
		.rot    (offset_rot),
		.q      (oq)
	);

	qpc_xform u_xf (
		.clk    (clk),
		.en     (en),
		.p      (pq),
		.o      (oq),
		.pos    (pos_s[UL-1]),
		.px     (placed_px),
		.py     (placed_py),
		.pz     (placed_pz),
		.rot    (placed_rot)
	);

endmodule
